FILE: rtl/sqe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sprite quad expander.
// Used by sqe_cordic and sprite_quad_expander_core; depends on nothing.
package sqe_pkg;

    localparam int unsigned ANGLE_TABLE_SIZE = 24;
    localparam int unsigned STEP_W = 5;
    localparam int unsigned SAT_W = 68;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [15:0] MIN_HALF_RESET = 16'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_LOC,
        ST_MUL,
        ST_EMIT,
        ST_BOX
    } t_state;

    function automatic logic [29:0] step_angle(input logic [STEP_W-1:0] idx);
        logic [29:0] a;
        unique case (idx)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_W'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < SAT_W'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic usable(input logic signed [31:0] v);
        return (v != S32_MAX) && (v != S32_MIN);
    endfunction

endpackage

FILE: rtl/sqe_cordic.sv
`timescale 1ns / 1ps
// Iterative shift-and-add sine/cosine unit, one rotation step per cycle.
// Depends on sqe_pkg for the angle table and gain constant.
module sqe_cordic #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    localparam int unsigned LIMIT = (CORDIC_STEPS < sqe_pkg::ANGLE_TABLE_SIZE)
                                    ? CORDIC_STEPS : sqe_pkg::ANGLE_TABLE_SIZE;

    logic                              r_busy;
    logic                              r_done;
    logic [sqe_pkg::STEP_W-1:0]        r_cnt;
    logic [1:0]                        r_quad;
    logic signed [31:0]                r_x;
    logic signed [31:0]                r_y;
    logic signed [32:0]                r_z;
    logic [1:0]                        quad;
    logic [15:0]                       rest;
    logic signed [31:0]                dx;
    logic signed [31:0]                dy;
    logic signed [32:0]                da;

    assign quad = 2'((i_angle + 16'h2000) >> 14);
    assign rest = i_angle - {quad, 14'd0};
    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign da = {3'd0, sqe_pkg::step_angle(r_cnt)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quad <= quad;
                r_x    <= sqe_pkg::GAIN_Q30;
                r_y    <= '0;
                r_z    <= {{1{rest[15]}}, rest, 16'd0};
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - da;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + da;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sqe_pkg::STEP_W'(LIMIT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (r_quad)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("cordic started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("cordic done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $fell(r_busy)) else $error("cordic done without run");
`endif

endmodule

FILE: rtl/sprite_quad_expander_core.sv
`timescale 1ns / 1ps
// Sprite quad expander top level: corners, UVs and running bounding box.
// Depends on sqe_pkg and sqe_cordic.
//
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_pos_x .. i_last_sprite
// result    out        o_valid / i_stall     o_corner_x .. o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (min_half_extent)
//
// Per sprite: the iterative rotation unit, four local edges, then per corner four
// products on the single shared multiplier and an emit; a last sprite adds the box.
// The next transaction is taken in the idle cycle that follows.
// Synchronous active-low reset clears control and the box bounds.
// A stalled result transaction holds the sequencer in its emit or box state.
module sprite_quad_expander_core #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_depth_z,
    input  logic [15:0]        i_angle,
    input  logic signed [31:0] i_size_w,
    input  logic signed [31:0] i_size_h,
    input  logic signed [31:0] i_pivot_x,
    input  logic signed [31:0] i_pivot_y,
    input  logic [63:0]        i_uv_rect,
    input  logic [63:0]        i_color,
    input  logic               i_last_sprite,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_corner_x,
    output logic signed [31:0] o_corner_y,
    output logic signed [31:0] o_corner_z,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [63:0]        o_corner_color,
    output logic [1:0]         o_corner_number,
    output logic               o_is_box,
    output logic [30:0]        o_half_x,
    output logic [30:0]        o_half_y,
    output logic [30:0]        o_half_z,
    output logic               o_last
);

    sqe_pkg::t_state r_state, n_state;

    logic [15:0]        r_min_half;
    logic signed [31:0] r_px, r_py, r_pz, r_w, r_h, r_kx, r_ky;
    logic [63:0]        r_uv, r_color;
    logic               r_last_sprite;
    logic signed [31:0] r_left, r_right, r_bot, r_top;
    logic [1:0]         r_idx;
    logic [1:0]         r_phase;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_cx, r_cy;
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];

    logic               r_o_valid;
    logic signed [31:0] r_o_x, r_o_y, r_o_z;
    logic [15:0]        r_o_u, r_o_v;
    logic [63:0]        r_o_color;
    logic [1:0]         r_o_num;
    logic               r_o_box;
    logic [30:0]        r_o_hx, r_o_hy, r_o_hz;
    logic               r_o_last;

    logic               accept, out_free, cordic_done;
    logic               do_loc, do_mul, do_emit, do_box;
    logic signed [31:0] cos_q30, sin_q30;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [66:0] rot_sum;
    logic signed [31:0] loc_val, rot_val, lx, ly;
    logic signed [31:0] emit_val [3];
    logic signed [31:0] box_mid [3];
    logic [30:0]        box_half [3];

    sqe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_angle (i_angle),
        .o_done  (cordic_done),
        .o_cos   (cos_q30),
        .o_sin   (sin_q30)
    );

    assign o_stall     = (r_state != sqe_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;

    always_comb begin
        case (r_idx)
            2'd0, 2'd3: lx = r_left;
            default:    lx = r_right;
        endcase
        case (r_idx)
            2'd0, 2'd1: ly = r_bot;
            default:    ly = r_top;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == sqe_pkg::ST_LOC) begin
            case (r_idx)
                2'd0: begin mul_a = -33'(r_kx);           mul_b = 33'(r_w); end
                2'd1: begin mul_a = 33'sd65536 - 33'(r_kx); mul_b = 33'(r_w); end
                2'd2: begin mul_a = -33'(r_ky);           mul_b = 33'(r_h); end
                default: begin mul_a = 33'sd65536 - 33'(r_ky); mul_b = 33'(r_h); end
            endcase
        end else begin
            case (r_phase)
                2'd0: begin mul_a = 33'(lx); mul_b = 33'(cos_q30); end
                2'd1: begin mul_a = 33'(ly); mul_b = 33'(sin_q30); end
                2'd2: begin mul_a = 33'(lx); mul_b = 33'(sin_q30); end
                default: begin mul_a = 33'(ly); mul_b = 33'(cos_q30); end
            endcase
        end
    end

    assign prod    = mul_a * mul_b;
    assign loc_val = sqe_pkg::sat32(sqe_pkg::SAT_W'((prod + 66'sd32768) >>> 16));
    assign rot_sum = (r_phase == 2'd1) ? (67'(r_acc) - 67'(prod)) : (67'(r_acc) + 67'(prod));
    assign rot_val = sqe_pkg::sat32(sqe_pkg::SAT_W'(
        ((rot_sum + 67'sd536870912) >>> 30)
        + 67'((r_phase == 2'd1) ? r_px : r_py)));

    assign emit_val[0] = r_cx;
    assign emit_val[1] = r_cy;
    assign emit_val[2] = r_pz;

    always_comb begin
        logic signed [31:0] lo, hi;
        logic signed [32:0] sum;
        logic [33:0]        diff;
        logic [32:0]        half;
        for (int a = 0; a < 3; a++) begin
            lo = r_lo[a];
            hi = r_hi[a];
            if (lo > hi) begin
                lo = '0;
                hi = '0;
            end
            sum  = 33'(lo) + 33'(hi);
            box_mid[a] = sum[32:1];
            diff = 34'(34'(hi) - 34'(lo) + 34'sd1);
            half = diff[33:1];
            if (half > 33'h7FFF_FFFF) begin
                half = 33'h7FFF_FFFF;
            end
            if (half < 33'(r_min_half)) begin
                half = 33'(r_min_half);
            end
            box_half[a] = half[30:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqe_pkg::ST_IDLE: if (accept) n_state = sqe_pkg::ST_ROT;
            sqe_pkg::ST_ROT:  if (cordic_done) n_state = sqe_pkg::ST_LOC;
            sqe_pkg::ST_LOC:  if (r_idx == 2'd3) n_state = sqe_pkg::ST_MUL;
            sqe_pkg::ST_MUL:  if (r_phase == 2'd3) n_state = sqe_pkg::ST_EMIT;
            sqe_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (r_idx != 2'd3) begin
                        n_state = sqe_pkg::ST_MUL;
                    end else if (r_last_sprite) begin
                        n_state = sqe_pkg::ST_BOX;
                    end else begin
                        n_state = sqe_pkg::ST_IDLE;
                    end
                end
            end
            sqe_pkg::ST_BOX:  if (out_free) n_state = sqe_pkg::ST_IDLE;
            default:          n_state = sqe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        do_loc  = 1'b0;
        do_mul  = 1'b0;
        do_emit = 1'b0;
        do_box  = 1'b0;
        unique case (r_state)
            sqe_pkg::ST_LOC:  do_loc  = 1'b1;
            sqe_pkg::ST_MUL:  do_mul  = 1'b1;
            sqe_pkg::ST_EMIT: do_emit = out_free;
            sqe_pkg::ST_BOX:  do_box  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sqe_pkg::ST_IDLE;
            r_min_half <= sqe_pkg::MIN_HALF_RESET;
            r_o_valid  <= 1'b0;
            r_idx      <= '0;
            r_phase    <= '0;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= sqe_pkg::S32_MAX;
                r_hi[a] <= sqe_pkg::S32_MIN;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_min_half <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (accept) begin
                r_px <= i_pos_x;  r_py <= i_pos_y;  r_pz <= i_depth_z;
                r_w  <= i_size_w; r_h  <= i_size_h;
                r_kx <= i_pivot_x; r_ky <= i_pivot_y;
                r_uv <= i_uv_rect; r_color <= i_color;
                r_last_sprite <= i_last_sprite;
                r_idx <= '0;
            end
            if (do_loc) begin
                case (r_idx)
                    2'd0: r_left  <= loc_val;
                    2'd1: r_right <= loc_val;
                    2'd2: r_bot   <= loc_val;
                    default: r_top <= loc_val;
                endcase
                r_idx   <= r_idx + 1'b1;
                r_phase <= '0;
            end
            if (do_mul) begin
                case (r_phase)
                    2'd0, 2'd2: r_acc <= prod;
                    2'd1: r_cx <= rot_val;
                    default: r_cy <= rot_val;
                endcase
                r_phase <= r_phase + 1'b1;
            end
            if (do_emit) begin
                r_o_valid <= 1'b1;
                r_o_x     <= r_cx;
                r_o_y     <= r_cy;
                r_o_z     <= r_pz;
                r_o_u     <= (r_idx == 2'd0 || r_idx == 2'd3) ? r_uv[15:0] : r_uv[47:32];
                r_o_v     <= (r_idx == 2'd0 || r_idx == 2'd1) ? r_uv[63:48] : r_uv[31:16];
                r_o_color <= r_color;
                r_o_num   <= r_idx;
                r_o_box   <= 1'b0;
                r_o_hx    <= '0;
                r_o_hy    <= '0;
                r_o_hz    <= '0;
                r_o_last  <= !r_last_sprite && (r_idx == 2'd3);
                r_idx     <= r_idx + 1'b1;
                r_phase   <= '0;
                for (int a = 0; a < 3; a++) begin
                    if (sqe_pkg::usable(emit_val[a])) begin
                        if (emit_val[a] < r_lo[a]) r_lo[a] <= emit_val[a];
                        if (emit_val[a] > r_hi[a]) r_hi[a] <= emit_val[a];
                    end
                end
            end
            if (do_box) begin
                r_o_valid <= 1'b1;
                r_o_x     <= box_mid[0];
                r_o_y     <= box_mid[1];
                r_o_z     <= box_mid[2];
                r_o_u     <= '0;
                r_o_v     <= '0;
                r_o_color <= '0;
                r_o_num   <= '0;
                r_o_box   <= 1'b1;
                r_o_hx    <= box_half[0];
                r_o_hy    <= box_half[1];
                r_o_hz    <= box_half[2];
                r_o_last  <= 1'b1;
                for (int a = 0; a < 3; a++) begin
                    r_lo[a] <= sqe_pkg::S32_MAX;
                    r_hi[a] <= sqe_pkg::S32_MIN;
                end
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_corner_x      = r_o_x;
    assign o_corner_y      = r_o_y;
    assign o_corner_z      = r_o_z;
    assign o_tex_u         = r_o_u;
    assign o_tex_v         = r_o_v;
    assign o_corner_color  = r_o_color;
    assign o_corner_number = r_o_num;
    assign o_is_box        = r_o_box;
    assign o_half_x        = r_o_hx;
    assign o_half_y        = r_o_hy;
    assign o_half_z        = r_o_hz;
    assign o_last          = r_o_last;

`ifndef ASSERT_OFF
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_emit || do_box) |=> r_o_valid) else $error("result not loaded");
    a_box_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_box) |-> r_o_last) else $error("box result without last");
    a_cordic_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == sqe_pkg::ST_ROT)) else $error("stray cordic done");
    a_box_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_box |=> (r_lo[0] == sqe_pkg::S32_MAX && r_hi[2] == sqe_pkg::S32_MIN))
        else $error("box bounds not cleared");
`endif

endmodule
